FILE: hw/rtl/teq_pkg.sv
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types and codes for the timed event queue.
// ----------------------------------------------------------------------------
package teq_pkg;

    localparam int TIME_W   = 48;
    localparam int HANDLE_W = 16;
    localparam int EVENT_W  = 16;
    localparam int FIRE_MAX = 16;
    localparam int FCNT_W   = 5;

    typedef enum logic [1:0] {
        CMD_SCHED  = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_SCHED  = 3'd0,
        KIND_REJECT = 3'd1,
        KIND_CANCEL = 3'd2,
        KIND_NOTFND = 3'd3,
        KIND_FIRED  = 3'd4
    } kind_t;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [31:0]         time_value;
        logic                is_relative;
        logic [EVENT_W-1:0]  event_id;
        logic [HANDLE_W-1:0] target_handle;
    } in_item_t;

    typedef struct packed {
        logic [2:0]          kind;
        logic [HANDLE_W-1:0] handle;
        logic [EVENT_W-1:0]  fired_event;
        logic                last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic  load;
        logic  scan_start;
        logic  emit;
        kind_t emit_kind;
        logic  emit_last;
        logic  commit;
        logic  cancel_clear;
        logic  fire_take;
        logic  adv_handle;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        cmd_t op;
        logic scan_done;
        logic free_found;
        logic hit;
        logic best_found;
        logic pend_valid;
        logic last_try;
        logic last_fire;
        logic out_free;
    } dp_status_t;

endpackage

FILE: hw/rtl/timed_event_queue_core.sv
// ----------------------------------------------------------------------------
// timed_event_queue_core
// Table of pending timed events with schedule, cancel and tick commands.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one command item (schedule, cancel or tick);
//   out_valid/out_ready carry result items, the final one of each command
//   marked by last. Command code 3 is taken and gives no result.
//   Every decision rests on a pass over the slot table, one slot a cycle
//   through the table memory's single read port.
//   Cancel: one pass. Schedule: one pass per handle tried (normally one).
//   Tick: one pass per entry fired plus one; when 16 fire, 16 passes and
//   a flush step for the last result.
//   A new item is taken only once the previous one has finished; a result
//   sits in the output register while the next item is being worked on.
//   When the receiver stalls, the sequencer waits before loading the next
//   result. Reset empties the table and clears time and handle counters;
//   the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module timed_event_queue_core #(
    parameter int SLOTS          = 16,
    parameter int INVALID_HANDLE = 65535
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  teq_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output teq_pkg::out_item_t out_data
);
    import teq_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t st;

    teq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (in_data.cmd),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    teq_datapath #(
        .SLOTS          (SLOTS),
        .INVALID_HANDLE (INVALID_HANDLE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .st        (st),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

FILE: hw/rtl/teq_datapath.sv
// ----------------------------------------------------------------------------
// teq_datapath
// Slot table, time and handle counters, slot scanner and result register.
// ----------------------------------------------------------------------------
module teq_datapath #(
    parameter int SLOTS          = 16,
    parameter int INVALID_HANDLE = 65535
) (
    input  logic                clk,
    input  logic                rst_n,
    input  teq_pkg::in_item_t   in_data,
    input  teq_pkg::ctrl_cmd_t  cmd,
    output teq_pkg::dp_status_t st,
    input  logic                out_ready,
    output logic                out_valid,
    output teq_pkg::out_item_t  out_data
);
    import teq_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
    localparam logic [HANDLE_W-1:0] INV_H = HANDLE_W'(INVALID_HANDLE);

    typedef struct packed {
        logic [TIME_W-1:0]   deadline;
        logic [EVENT_W-1:0]  ev;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    // latched item and counters
    cmd_t                op_reg;
    logic [31:0]         tv_reg;
    logic                rel_reg;
    logic [EVENT_W-1:0]  ev_reg;
    logic [HANDLE_W-1:0] tgt_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [HANDLE_W-1:0] next_handle_reg, next_handle_next;
    logic [HANDLE_W-1:0] tries_reg;
    logic [SLOTS-1:0]    valid_reg;

    // table memory
    entry_t              mem [SLOTS];
    entry_t              rd_reg;

    // scanner
    logic                scan_on_reg, live_reg, done_reg;
    logic [IW-1:0]       idx_reg, rd_idx_reg;
    logic                free_found_reg, hit_reg, best_found_reg;
    logic [IW-1:0]       free_idx_reg, hit_idx_reg, best_idx_reg;
    logic [TIME_W-1:0]   best_dl_reg;
    logic [HANDLE_W-1:0] best_h_reg;
    logic [EVENT_W-1:0]  best_ev_reg;

    // pending fire and output
    logic                pend_valid_reg;
    logic [HANDLE_W-1:0] pend_h_reg;
    logic [EVENT_W-1:0]  pend_ev_reg;
    logic [FCNT_W-1:0]   fire_cnt_reg;
    logic                out_valid_reg;
    out_item_t           out_reg;

    logic [HANDLE_W-1:0] key;
    logic                rd_valid, is_due, is_better;
    logic [TIME_W-1:0]   new_deadline;
    out_item_t           emit_item;

    // compare key and per-entry checks
    assign key       = (op_reg == CMD_CANCEL) ? tgt_reg : next_handle_reg;
    assign rd_valid  = valid_reg[rd_idx_reg];
    assign is_due    = rd_valid && (rd_reg.deadline <= time_reg);
    assign is_better = !best_found_reg || (rd_reg.deadline < best_dl_reg) ||
                       ((rd_reg.deadline == best_dl_reg) && (rd_reg.handle < best_h_reg));

    assign new_deadline = rel_reg ? (time_reg + {16'd0, tv_reg}) : {16'd0, tv_reg};

    always_comb
    begin
        next_handle_next = next_handle_reg + 1'b1;
        if (next_handle_next == INV_H)
        begin
            next_handle_next = '0;
        end
    end

    // result selection
    always_comb
    begin
        emit_item.kind        = cmd.emit_kind;
        emit_item.last        = cmd.emit_last;
        emit_item.fired_event = '0;
        unique case (cmd.emit_kind)
            KIND_SCHED:  emit_item.handle = next_handle_reg;
            KIND_REJECT: emit_item.handle = INV_H;
            KIND_CANCEL: emit_item.handle = tgt_reg;
            KIND_NOTFND: emit_item.handle = tgt_reg;
            KIND_FIRED:
            begin
                emit_item.handle      = pend_h_reg;
                emit_item.fired_event = pend_ev_reg;
            end
            default:     emit_item.handle = INV_H;
        endcase
    end

    // table memory
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            mem[free_idx_reg] <= '{deadline: new_deadline, ev: ev_reg, handle: next_handle_reg};
        end
        rd_reg <= mem[idx_reg];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg          <= CMD_NONE;
            time_reg        <= '0;
            next_handle_reg <= '0;
            tries_reg       <= '0;
            valid_reg       <= '0;
            scan_on_reg     <= 1'b0;
            live_reg        <= 1'b0;
            done_reg        <= 1'b0;
            pend_valid_reg  <= 1'b0;
            fire_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                op_reg         <= cmd_t'(in_data.cmd);
                tries_reg      <= '0;
                pend_valid_reg <= 1'b0;
                fire_cnt_reg   <= '0;
                if (cmd_t'(in_data.cmd) == CMD_TICK)
                begin
                    time_reg <= time_reg + 1'b1;
                end
            end
            if (cmd.adv_handle)
            begin
                next_handle_reg <= next_handle_next;
                tries_reg       <= tries_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (cmd.cancel_clear)
            begin
                valid_reg[hit_idx_reg] <= 1'b0;
            end
            if (cmd.fire_take)
            begin
                valid_reg[best_idx_reg] <= 1'b0;
                pend_valid_reg          <= 1'b1;
                fire_cnt_reg            <= fire_cnt_reg + 1'b1;
            end

            // scanner sequencing
            if (cmd.scan_start)
            begin
                scan_on_reg <= 1'b1;
            end
            else if (scan_on_reg && (idx_reg == LAST_IDX))
            begin
                scan_on_reg <= 1'b0;
            end
            live_reg <= scan_on_reg && !cmd.scan_start;
            done_reg <= live_reg && (rd_idx_reg == LAST_IDX);

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: latched item, scan accumulators, pending fire, result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tv_reg  <= in_data.time_value;
            rel_reg <= in_data.is_relative;
            ev_reg  <= in_data.event_id;
            tgt_reg <= in_data.target_handle;
        end
        if (cmd.scan_start)
        begin
            idx_reg <= '0;
        end
        else if (scan_on_reg)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        rd_idx_reg <= idx_reg;

        if (cmd.scan_start)
        begin
            free_found_reg <= 1'b0;
            hit_reg        <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else if (live_reg)
        begin
            if (!rd_valid && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= rd_idx_reg;
            end
            if (rd_valid && (rd_reg.handle == key) && !hit_reg)
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= rd_idx_reg;
            end
            if (is_due && is_better)
            begin
                best_found_reg <= 1'b1;
                best_idx_reg   <= rd_idx_reg;
                best_dl_reg    <= rd_reg.deadline;
                best_h_reg     <= rd_reg.handle;
                best_ev_reg    <= rd_reg.ev;
            end
        end

        if (cmd.fire_take)
        begin
            pend_h_reg  <= best_h_reg;
            pend_ev_reg <= best_ev_reg;
        end
        if (cmd.emit)
        begin
            out_reg <= emit_item;
        end
    end

    // status to controller
    assign st.op         = op_reg;
    assign st.scan_done  = done_reg;
    assign st.free_found = free_found_reg;
    assign st.hit        = hit_reg;
    assign st.best_found = best_found_reg;
    assign st.pend_valid = pend_valid_reg;
    assign st.last_try   = ((tries_reg + 1'b1) == INV_H);
    assign st.last_fire  = ((fire_cnt_reg + 1'b1) == FCNT_W'(FIRE_MAX));
    assign st.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: hw/rtl/teq_ctrl.sv
// ----------------------------------------------------------------------------
// teq_ctrl
// Sequencer: runs slot scans and decides each item's results.
// ----------------------------------------------------------------------------
module teq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_cmd,
    output logic                in_ready,
    input  teq_pkg::dp_status_t st,
    output teq_pkg::ctrl_cmd_t  cmd
);
    import teq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_SCAN    = 4'b0010,
        S_RESOLVE = 4'b0100,
        S_FLUSH   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.emit_kind = KIND_SCHED;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (cmd_t'(in_cmd) != CMD_NONE)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (st.scan_done)
                begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                if (st.out_free)
                begin
                    state_next    = S_IDLE;
                    cmd.emit_last = 1'b1;
                    unique case (st.op)
                        CMD_SCHED:
                        begin
                            if (!st.free_found)
                            begin
                                cmd.emit      = 1'b1;
                                cmd.emit_kind = KIND_REJECT;
                            end
                            else
                            begin
                                cmd.adv_handle = 1'b1;
                                if (!st.hit)
                                begin
                                    cmd.commit    = 1'b1;
                                    cmd.emit      = 1'b1;
                                    cmd.emit_kind = KIND_SCHED;
                                end
                                else if (st.last_try)
                                begin
                                    cmd.emit      = 1'b1;
                                    cmd.emit_kind = KIND_REJECT;
                                end
                                else
                                begin
                                    cmd.scan_start = 1'b1;
                                    state_next     = S_SCAN;
                                end
                            end
                        end
                        CMD_CANCEL:
                        begin
                            cmd.emit         = 1'b1;
                            cmd.cancel_clear = st.hit;
                            cmd.emit_kind    = st.hit ? KIND_CANCEL : KIND_NOTFND;
                        end
                        CMD_TICK:
                        begin
                            cmd.emit_kind = KIND_FIRED;
                            cmd.emit      = st.pend_valid;
                            if (st.best_found)
                            begin
                                // earlier fire goes out now, this one waits
                                cmd.emit_last = 1'b0;
                                cmd.fire_take = 1'b1;
                                if (st.last_fire)
                                begin
                                    state_next = S_FLUSH;
                                end
                                else
                                begin
                                    cmd.scan_start = 1'b1;
                                    state_next     = S_SCAN;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FLUSH:
            begin
                if (st.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_FIRED;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for timed_event_queue_core: directed and random
// schedule/cancel/tick items, predicted against an internal table model.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import teq_pkg::*;

    localparam int NSLOT   = 16;
    localparam int BAD_H   = 65535;
    localparam int LIMIT   = 400000;
    localparam bit [HANDLE_W-1:0] BAD_HV = HANDLE_W'(BAD_H);

    // table model and expected result store
    class event_table_sb;
        bit                slot_used [NSLOT];
        bit [TIME_W-1:0]   slot_due  [NSLOT];
        bit [EVENT_W-1:0]  slot_ev   [NSLOT];
        bit [HANDLE_W-1:0] slot_hdl  [NSLOT];
        bit [TIME_W-1:0]   now;
        bit [HANDLE_W-1:0] next_hdl;
        out_item_t         pending_results [$];
        int                errors;

        function int find_hdl(bit [HANDLE_W-1:0] h);
            for (int i = 0; i < NSLOT; i++)
                if (slot_used[i] && slot_hdl[i] == h)
                    return i;
            return -1;
        endfunction

        function void push_result(kind_t k, bit [15:0] h, bit [15:0] ev);
            out_item_t r;
            r.kind = k;
            r.handle = h;
            r.fired_event = ev;
            r.last = 1'b0;
            pending_results.push_back(r);
        endfunction

        function void note_item(in_item_t it);
            int free_slot;
            int best;
            int n;
            bit got;
            bit [15:0] h;
            bit [15:0] cand;
            free_slot = -1;
            n = 0;
            got = 0;
            h = '0;
            case (cmd_t'(it.cmd))
                CMD_SCHED:
                begin
                    for (int i = 0; i < NSLOT; i++)
                        if (!slot_used[i] && free_slot < 0)
                            free_slot = i;
                    if (free_slot >= 0)
                    begin
                        for (int t = 0; t < BAD_H && !got; t++)
                        begin
                            cand = next_hdl;
                            next_hdl = (16'(next_hdl + 16'd1) == BAD_HV) ? 16'd0
                                                                         : 16'(next_hdl + 16'd1);
                            if (cand != BAD_HV && find_hdl(cand) < 0)
                            begin
                                h = cand;
                                got = 1;
                            end
                        end
                    end
                    if (got)
                    begin
                        slot_used[free_slot] = 1;
                        slot_due[free_slot] = it.is_relative ? now + it.time_value
                                                             : {16'd0, it.time_value};
                        slot_ev[free_slot] = it.event_id;
                        slot_hdl[free_slot] = h;
                        push_result(KIND_SCHED, h, '0);
                    end
                    else
                        push_result(KIND_REJECT, BAD_HV, '0);
                    n = 1;
                end
                CMD_CANCEL:
                begin
                    best = find_hdl(it.target_handle);
                    if (best >= 0)
                    begin
                        slot_used[best] = 0;
                        push_result(KIND_CANCEL, it.target_handle, '0);
                    end
                    else
                        push_result(KIND_NOTFND, it.target_handle, '0);
                    n = 1;
                end
                CMD_TICK:
                begin
                    now = now + 48'd1;
                    while (n < FIRE_MAX)
                    begin
                        best = -1;
                        for (int i = 0; i < NSLOT; i++)
                        begin
                            if (!slot_used[i] || slot_due[i] > now)
                                continue;
                            if (best < 0 || slot_due[i] < slot_due[best] ||
                                (slot_due[i] == slot_due[best] &&
                                 slot_hdl[i] < slot_hdl[best]))
                                best = i;
                        end
                        if (best < 0)
                            break;
                        slot_used[best] = 0;
                        push_result(KIND_FIRED, slot_hdl[best], slot_ev[best]);
                        n++;
                    end
                end
                default: ;
            endcase
            if (n > 0)
                pending_results[$].last = 1'b1;
        endfunction

        task report(string what, out_item_t got_r, out_item_t exp_r);
            $display("mismatch %s: got %0d/%0d/%0d/%0d exp %0d/%0d/%0d/%0d", what,
                     got_r.kind, got_r.handle, got_r.fired_event, got_r.last,
                     exp_r.kind, exp_r.handle, exp_r.fired_event, exp_r.last);
            errors++;
        endtask

        task check_result(out_item_t r);
            out_item_t e;
            if (pending_results.size() == 0)
            begin
                report("unexpected", r, '0);
                return;
            end
            e = pending_results.pop_front();
            if (r.kind != e.kind) report("kind", r, e);
            if (r.handle != e.handle) report("handle", r, e);
            if (r.fired_event != e.fired_event) report("event", r, e);
            if (r.last != e.last) report("last", r, e);
        endtask
    endclass

    logic      clk = 0;
    logic      rst_n = 0;
    logic      in_valid = 0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 0;
    out_item_t out_data;

    event_table_sb sb = new();
    int  cycles = 0;
    bit  calm = 0;        // no idling in the last part
    bit  hold_sink = 0;   // long receiver hold-off
    bit  sink_on = 0;
    bit [HANDLE_W-1:0] recent_hdl [$];

    timed_event_queue_core #(.SLOTS(NSLOT), .INVALID_HANDLE(BAD_H)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // result sampling and handle capture
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (out_valid && out_ready)
        begin
            if (out_data.kind == KIND_SCHED)
                recent_hdl.push_back(out_data.handle);
            sb.check_result(out_data);
        end
        if (cycles > LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // receiver readiness with idle bursts
    initial
    begin
        int burst;
        wait (sink_on);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
                out_ready <= 0;
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 4);
                out_ready <= 0;
                repeat (burst - 1) @(negedge clk);
            end
            else
                out_ready <= 1;
        end
    end

    // offer one item from the next falling edge; returns at the accepting edge
    task automatic send_item(in_item_t it);
        @(negedge clk);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_item(it);
    endtask

    task automatic sched(bit [31:0] tv, bit rel, bit [15:0] ev);
        in_item_t it;
        it = '0;
        it.cmd = CMD_SCHED;
        it.time_value = tv;
        it.is_relative = rel;
        it.event_id = ev;
        it.target_handle = 16'($urandom);
        send_item(it);
    endtask

    task automatic cmd_only(cmd_t c, bit [15:0] h);
        in_item_t it;
        it = '0;
        it.cmd = c;
        it.target_handle = h;
        it.time_value = $urandom;
        it.event_id = 16'($urandom);
        it.is_relative = 1'($urandom);
        send_item(it);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 0;
        while (sb.pending_results.size() != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    function automatic bit [15:0] pick_hdl();
        if (recent_hdl.size() == 0 || $urandom_range(0, 4) == 0)
            return 16'($urandom_range(0, 65534));
        return recent_hdl[$urandom_range(0, recent_hdl.size() - 1)];
    endfunction

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        sink_on = 1;

        // directed: ticks on empty, full table, ties, cancels, unused command
        cmd_only(CMD_TICK, 16'd0);
        cmd_only(CMD_CANCEL, 16'd65534);
        cmd_only(CMD_CANCEL, 16'd0);
        for (int i = 0; i < NSLOT; i++)
            sched(32'd3, 1'b0, 16'(16'hFFFF - i));
        sched(32'hFFFFFFFF, 1'b1, 16'h1234);
        cmd_only(CMD_CANCEL, 16'd5);
        cmd_only(CMD_CANCEL, 16'd5);
        cmd_only(CMD_NONE, 16'd1);
        sched(32'hFFFFFFFF, 1'b0, 16'h0);
        cmd_only(CMD_TICK, 16'd0);
        cmd_only(CMD_TICK, 16'd0);
        cmd_only(CMD_TICK, 16'd0);
        sched(32'd0, 1'b1, 16'hA5A5);
        cmd_only(CMD_TICK, 16'd0);
        drain();

        // receiver hold-off while the sender keeps offering items
        hold_sink = 1;
        fork
        begin
            repeat (300) @(negedge clk);
            hold_sink = 0;
        end
        for (int i = 0; i < 6; i++)
            sched($urandom_range(0, 3), 1'b1, 16'($urandom));
        join
        cmd_only(CMD_TICK, 16'd0);
        cmd_only(CMD_TICK, 16'd0);
        cmd_only(CMD_TICK, 16'd0);
        cmd_only(CMD_TICK, 16'd0);
        drain();

        // random: schedules, often with short delays, cancels and ticks
        for (int n = 0; n < 130; n++)
        begin
            if (n == 100)
                calm = 1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: sched($urandom_range(0, 1) ? $urandom_range(0, 12) : $urandom,
                                  $urandom_range(0, 3) != 0, 16'($urandom));
                4, 5:       cmd_only(CMD_CANCEL, pick_hdl());
                9:          cmd_only($urandom_range(0, 7) == 0 ? CMD_NONE : CMD_TICK, 16'd0);
                default:    cmd_only(CMD_TICK, 16'd0);
            endcase
            if (n == 65)
                drain();
        end
        drain();
        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
